/* hw/rtl/assert_macros.svh */
// Assertion macros for the checker file.
// No dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication.
`define ABKF_ASSERT_IMP(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication.
`define ABKF_ASSERT_NXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`endif

/* hw/rtl/abkf_pkg.sv */
// Types, constants and helpers of the angle/bias Kalman filter.
// No dependencies.
package abkf_pkg;

  localparam int COV_FRAC_BITS = 30;

  localparam logic [1:0] REG_QA = 2'd0;
  localparam logic [1:0] REG_QB = 2'd1;
  localparam logic [1:0] REG_R  = 2'd2;
  localparam logic [1:0] REG_DT = 2'd3;

  localparam logic [30:0] QA_RESET = 31'd107374;
  localparam logic [30:0] QB_RESET = 31'd1073742;
  localparam logic [30:0] R_RESET  = 31'd10737418;
  localparam logic [30:0] DT_RESET = 31'd10737418;

  localparam logic signed [31:0] COV_ONE = 32'sd1 <<< COV_FRAC_BITS;

  typedef enum logic [3:0] {
    OP_PRED  = 4'd0,
    OP_P00   = 4'd1,
    OP_P01   = 4'd2,
    OP_K0E   = 4'd3,
    OP_K1E   = 4'd4,
    OP_K1P00 = 4'd5,
    OP_K0P00 = 4'd6,
    OP_K1P01 = 4'd7,
    OP_K0P01 = 4'd8
  } op_t;

  typedef struct packed {
    logic load_in;
    logic mul_go;
    logic wb;
    logic div_start;
    logic div_sel;
    logic out_load;
    op_t  op;
  } cmd_t;

  typedef struct packed {
    logic div_done;
    logic out_free;
  } stat_t;

  function automatic logic signed [31:0] sat32(input logic signed [39:0] x);
    logic signed [31:0] r;
    if (x > 40'sd2147483647) r = 32'sh7FFFFFFF;
    else if (x < -40'sd2147483648) r = 32'sh80000000;
    else r = x[31:0];
    return r;
  endfunction

endpackage

/* hw/rtl/abkf_div.sv */
// Iterative signed divider for the gains: (num << COV_FRAC_BITS) / den,
// truncated toward zero, saturated to 32 bits, zero when den is zero. Uses abkf_pkg.
module abkf_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [31:0] num,
  input  logic signed [33:0] den,
  output logic               done,
  output logic signed [31:0] quot
);
  import abkf_pkg::*;

  typedef enum logic [2:0] {
    D_IDLE  = 3'b001,
    D_CHECK = 3'b010,
    D_ITER  = 3'b100
  } dstate_t;

  dstate_t     state;
  logic        neg;
  logic        zero;
  logic [63:0] dividend;
  logic [33:0] dmag;
  logic [32:0] rem;
  logic [31:0] low;
  logic [4:0]  cnt;

  logic [32:0] nmag;
  logic        ovf;
  logic [34:0] trial;
  logic [31:0] qfinal;

  always_comb begin
    nmag   = num[31] ? (33'd0 - 33'(num)) : 33'(num);
    ovf    = {1'b0, dividend} >= (65'(dmag) << 31);
    trial  = {1'b0, rem, low[31]} - {1'b0, dmag};
    qfinal = {low[30:0], ~trial[34]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        D_IDLE: begin
          if (start) begin
            neg      <= num[31] ^ den[33];
            zero     <= (den == 34'sd0);
            dividend <= 64'(nmag) << COV_FRAC_BITS;
            dmag     <= den[33] ? (34'd0 - $unsigned(den)) : $unsigned(den);
            state    <= D_CHECK;
          end
        end
        D_CHECK: begin
          priority if (zero) begin
            quot  <= 32'sd0;
            done  <= 1'b1;
            state <= D_IDLE;
          end else if (ovf) begin
            quot  <= neg ? 32'sh80000000 : 32'sh7FFFFFFF;
            done  <= 1'b1;
            state <= D_IDLE;
          end else begin
            // high half is below the divisor here
            rem   <= dividend[64-1-:33] >> 1;
            low   <= dividend[31:0];
            cnt   <= 5'd31;
            state <= D_ITER;
          end
        end
        D_ITER: begin
          rem <= trial[34] ? {rem[31:0], low[31]} : trial[32:0];
          low <= qfinal;
          cnt <= cnt - 5'd1;
          if (cnt == 5'd0) begin
            quot  <= neg ? (32'sd0 - $signed(qfinal)) : $signed(qfinal);
            done  <= 1'b1;
            state <= D_IDLE;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/abkf_ctrl.sv */
// Sequencer of the Kalman step: issues input load, multiply, writeback, divide and output load commands.
// Uses abkf_pkg.
module abkf_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  abkf_pkg::stat_t stat,
  output abkf_pkg::cmd_t  cmd
);
  import abkf_pkg::*;

  typedef enum logic [5:0] {
    C_IDLE   = 6'b000001,
    C_MUL    = 6'b000010,
    C_WB     = 6'b000100,
    C_DSTART = 6'b001000,
    C_DWAIT  = 6'b010000,
    C_OUT    = 6'b100000
  } cstate_t;

  cstate_t state;
  op_t     op;
  logic    dsel;

  assign in_ready = (state == C_IDLE);

  always_comb begin
    cmd           = '0;
    cmd.op        = op;
    cmd.div_sel   = dsel;
    cmd.load_in   = (state == C_IDLE) && in_valid;
    cmd.mul_go    = (state == C_MUL);
    cmd.wb        = (state == C_WB);
    cmd.div_start = (state == C_DSTART);
    cmd.out_load  = (state == C_OUT) && stat.out_free;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= C_IDLE;
      op    <= OP_PRED;
      dsel  <= 1'b0;
    end else begin
      unique case (state)
        C_IDLE: begin
          if (in_valid) begin
            op    <= OP_PRED;
            state <= C_MUL;
          end
        end
        C_MUL: state <= C_WB;
        C_WB: begin
          priority if (op == OP_P01) begin
            dsel  <= 1'b0;
            state <= C_DSTART;
          end else if (op == OP_K0P01) begin
            state <= C_OUT;
          end else begin
            op    <= op_t'(4'(op + 4'd1));
            state <= C_MUL;
          end
        end
        C_DSTART: state <= C_DWAIT;
        C_DWAIT: begin
          if (stat.div_done) begin
            if (!dsel) begin
              dsel  <= 1'b1;
              state <= C_DSTART;
            end else begin
              op    <= OP_K0E;
              state <= C_MUL;
            end
          end
        end
        C_OUT: if (stat.out_free) state <= C_IDLE;
        default: state <= C_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/abkf_dpath.sv */
// Datapath: filter state, configuration registers, shared multiplier, divider
// and output register. Uses abkf_pkg and abkf_div.
module abkf_dpath (
  input  logic               clk,
  input  logic               rst,
  input  logic               wr_en,
  input  logic [1:0]         wr_index,
  input  logic [30:0]        wr_data,
  input  logic [63:0]        in_data,
  input  abkf_pkg::cmd_t     cmd,
  output abkf_pkg::stat_t    stat,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [31:0]        out_data
);
  import abkf_pkg::*;

  logic [30:0] qa, qb, rr, dt;
  logic signed [31:0] angle, bias, p00, p01, p10, p11;
  logic signed [31:0] meas, rate, pred, q00, q01, q10, q11, k0, k1;
  logic signed [67:0] prod;

  logic signed [33:0] ma, mb, den, err;
  logic signed [39:0] f;
  logic signed [39:0] qa_x, qb_x;
  logic signed [31:0] dnum, dquot;
  logic               ddone;

  always_comb begin
    err  = 34'(meas) - 34'(pred);
    f    = 40'(prod >>> COV_FRAC_BITS);
    qa_x = $signed({9'd0, qa});
    qb_x = $signed({9'd0, qb});
    den  = 34'(q00) + $signed({3'd0, rr});
    dnum = cmd.div_sel ? q10 : q00;
    ma   = 34'(k0);
    mb   = err;
    unique case (cmd.op)
      OP_PRED:  begin ma = 34'(rate) - 34'(bias); mb = $signed({3'd0, dt}); end
      OP_P00:   begin ma = 34'(p01) + 34'(p10);   mb = $signed({3'd0, dt}); end
      OP_P01:   begin ma = 34'(p11);              mb = $signed({3'd0, dt}); end
      OP_K0E:   begin ma = 34'(k0); mb = err; end
      OP_K1E:   begin ma = 34'(k1); mb = err; end
      OP_K1P00: begin ma = 34'(k1); mb = 34'(q00); end
      OP_K0P00: begin ma = 34'(k0); mb = 34'(q00); end
      OP_K1P01: begin ma = 34'(k1); mb = 34'(q01); end
      OP_K0P01: begin ma = 34'(k0); mb = 34'(q01); end
      default:  begin ma = 34'(k0); mb = err; end
    endcase
  end

  abkf_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (dnum),
    .den   (den),
    .done  (ddone),
    .quot  (dquot)
  );

  assign stat.div_done = ddone;
  assign stat.out_free = !out_valid || out_ready;

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      qa <= QA_RESET;
      qb <= QB_RESET;
      rr <= R_RESET;
      dt <= DT_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_QA: qa <= wr_data;
        REG_QB: qb <= wr_data;
        REG_R:  rr <= wr_data;
        REG_DT: dt <= wr_data;
        default: ;
      endcase
    end
  end

  // working registers, no reset
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      meas <= in_data[31:0];
      rate <= in_data[63:32];
    end
    if (cmd.mul_go) prod <= ma * mb;
    if (ddone) begin
      if (cmd.div_sel) k1 <= dquot;
      else k0 <= dquot;
    end
    if (cmd.wb) begin
      unique case (cmd.op)
        OP_PRED: pred <= sat32(40'(angle) + f);
        OP_P00:  q00  <= sat32(40'(p00) + qa_x - f);
        OP_P01: begin
          q01 <= sat32(40'(p01) - f);
          q10 <= sat32(40'(p10) - f);
          q11 <= sat32(40'(p11) + qb_x);
        end
        default: ;
      endcase
    end
  end

  // filter state
  always_ff @(posedge clk) begin
    if (rst) begin
      angle <= '0;
      bias  <= '0;
      p00   <= COV_ONE;
      p01   <= '0;
      p10   <= '0;
      p11   <= COV_ONE;
    end else if (cmd.wb) begin
      unique case (cmd.op)
        OP_K0E:   angle <= sat32(40'(pred) + f);
        OP_K1E:   bias  <= sat32(40'(bias) + f);
        OP_K1P00: p10   <= sat32(40'(q10) - f);
        OP_K0P00: p00   <= sat32(40'(q00) - f);
        OP_K1P01: p11   <= sat32(40'(q11) - f);
        OP_K0P01: p01   <= sat32(40'(q01) - f);
        default: ;
      endcase
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) out_data <= angle;
  end

endmodule

/* hw/rtl/angle_bias_kalman_filter.sv */
// Top level of the angle/gyro-bias Kalman filter: controller plus datapath.
// Uses abkf_pkg, abkf_ctrl, abkf_dpath.
//
//   channel  | direction | handshake          | payload
//   s_*      | in        | s_tvalid/s_tready  | measured_angle, gyro_rate
//   m_*      | out       | m_tvalid/m_tready  | filtered_angle
//   wr_*     | in        | wr_en              | register index, 31-bit value
//
// Each sample runs from its accept through nine multiplies on the one shared
// multiplier (a multiply and a writeback step each), two gain divisions (start,
// check, 32 quotient steps, done; a zero or saturated gain ends after the check),
// and the output load.
// Reset is synchronous; filter state returns to zero angle and bias, unit covariance.
// A new sample is taken only in idle; a stalled result holds the block in its last step.
module angle_bias_kalman_filter (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] measured_angle, [63:32] gyro_rate
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] filtered_angle
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [30:0] wr_data
);
  import abkf_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  abkf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  abkf_dpath u_dpath (
    .clk       (clk),
    .rst       (rst),
    .wr_en     (wr_en),
    .wr_index  (wr_index),
    .wr_data   (wr_data),
    .in_data   (s_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata)
  );

endmodule

/* hw/rtl/abkf_checker.sv */
// Port-level checks of the Kalman filter, bound to the top level.
// Uses assert_macros.svh.
`include "assert_macros.svh"

module abkf_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);

  `ABKF_ASSERT_NXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid)
  `ABKF_ASSERT_NXT(a_out_stable, clk, rst, m_tvalid && !m_tready, $stable(m_tdata))
  `ABKF_ASSERT_NXT(a_busy_after_accept, clk, rst, s_tvalid && s_tready, !s_tready)
  `ABKF_ASSERT_IMP(a_result_from_busy, clk, rst, $rose(m_tvalid), $past(!s_tready))

endmodule

bind angle_bias_kalman_filter abkf_checker u_abkf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

/* tb/angle_bias_kalman_filter_tb.sv */
// Self-checking testbench for angle_bias_kalman_filter: random sample stream with
// idle bursts, register phases and an in-bench Kalman predictor. Uses abkf_pkg.
`timescale 1ns / 1ps

module angle_bias_kalman_filter_tb;
  import abkf_pkg::*;

  typedef logic signed [95:0] wide_t;
  typedef enum logic [1:0] {K_SAMPLE, K_WRITE, K_DRAIN} kind_t;
  typedef struct {
    kind_t       kind;
    logic [63:0] data;
    logic [1:0]  index;
  } job_t;

  localparam int LIMIT = 3000000;
  localparam int QUIET_AFTER = 1250;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [63:0] s_tdata = '0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic wr_en = 1'b0;
  logic [1:0] wr_index = REG_QA;
  logic [30:0] wr_data = '0;

  job_t jobs[$];
  logic signed [31:0] angle_q[$];
  int fails = 0;
  int cycles = 0;
  int sent = 0;
  int results = 0;

  // filter state mirror
  logic [30:0] qa = QA_RESET, qb = QB_RESET, rn = R_RESET, dt = DT_RESET;
  logic signed [31:0] ang = 0, bias = 0;
  logic signed [31:0] cov[4] = '{COV_ONE, 0, 0, COV_ONE};

  angle_bias_kalman_filter i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .wr_en(wr_en), .wr_index(wr_index), .wr_data(wr_data)
  );

  function automatic logic signed [31:0] clamp32(input wide_t x);
    if (x > 96'sd2147483647) return 32'sh7FFFFFFF;
    if (x < -96'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic logic signed [31:0] gain_of(input wide_t num, input wide_t den);
    if (den == 0) return 0;
    return clamp32((num <<< COV_FRAC_BITS) / den);
  endfunction

  // Advance the mirrored filter by one sample; returns the new angle estimate.
  function automatic logic signed [31:0] kalman_step(input logic [63:0] d);
    wide_t meas, rate, w_dt, w_ang, w_bias, c0, c1, c2, c3;
    wide_t pred, p00, p01, p10, p11, s, e, k0, k1;
    meas = $signed(d[31:0]);
    rate = $signed(d[63:32]);
    w_dt = {65'b0, dt};
    w_ang = ang;
    w_bias = bias;
    c0 = cov[0]; c1 = cov[1]; c2 = cov[2]; c3 = cov[3];
    pred = clamp32(w_ang + (((rate - w_bias) * w_dt) >>> COV_FRAC_BITS));
    p00 = clamp32(c0 + $signed({65'b0, qa}) - (((c1 + c2) * w_dt) >>> COV_FRAC_BITS));
    p01 = clamp32(c1 - ((c3 * w_dt) >>> COV_FRAC_BITS));
    p10 = clamp32(c2 - ((c3 * w_dt) >>> COV_FRAC_BITS));
    p11 = clamp32(c3 + {65'b0, qb});
    s = p00 + {65'b0, rn};
    k0 = gain_of(p00, s);
    k1 = gain_of(p10, s);
    e = meas - pred;
    ang = clamp32(pred + ((k0 * e) >>> COV_FRAC_BITS));
    bias = clamp32(w_bias + ((k1 * e) >>> COV_FRAC_BITS));
    cov[2] = clamp32(p10 - ((k1 * p00) >>> COV_FRAC_BITS));
    cov[0] = clamp32(p00 - ((k0 * p00) >>> COV_FRAC_BITS));
    cov[3] = clamp32(p11 - ((k1 * p01) >>> COV_FRAC_BITS));
    cov[1] = clamp32(p01 - ((k0 * p01) >>> COV_FRAC_BITS));
    return ang;
  endfunction

  task automatic add_sample(input logic [31:0] meas, input logic [31:0] rate);
    jobs.push_back('{K_SAMPLE, {rate, meas}, REG_QA});
  endtask

  task automatic add_regs(input logic [30:0] a, input logic [30:0] b,
                          input logic [30:0] r, input logic [30:0] t);
    jobs.push_back('{K_DRAIN, '0, REG_QA});
    jobs.push_back('{K_WRITE, {33'b0, a}, REG_QA});
    jobs.push_back('{K_WRITE, {33'b0, b}, REG_QB});
    jobs.push_back('{K_WRITE, {33'b0, r}, REG_R});
    jobs.push_back('{K_WRITE, {33'b0, t}, REG_DT});
  endtask

  function automatic logic [31:0] rnd_value();
    if ($urandom_range(9) < 3) return $urandom;
    return $urandom_range(11796480) - 5898240;  // about +/-90 degrees
  endfunction

  task automatic add_random(input int n);
    repeat (n) add_sample(rnd_value(), rnd_value());
  endtask

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    // directed: field extremes under reset settings
    add_sample(32'h0, 32'h0);
    add_sample(32'h7FFFFFFF, 32'h0);
    add_sample(32'h80000000, 32'h0);
    add_sample(32'h0, 32'h7FFFFFFF);
    add_sample(32'h0, 32'h80000000);
    add_sample(32'h7FFFFFFF, 32'h7FFFFFFF);
    add_sample(32'h80000000, 32'h80000000);
    add_sample(32'hFFFFFFFF, 32'h00000001);
    add_sample(32'h00010000, 32'hFFFF0000);
    add_sample(32'h005A0000, 32'h00000000);
    // extreme registers drive saturation of angle, bias and gains
    add_regs(31'h7FFFFFFF, 31'h7FFFFFFF, 31'h7FFFFFFF, 31'h40000000);
    add_sample(32'h7FFFFFFF, 32'h80000000);
    add_sample(32'h80000000, 32'h7FFFFFFF);
    add_sample(32'h7FFFFFFF, 32'h7FFFFFFF);
    add_sample(32'h80000000, 32'h80000000);
    add_random(200);
    // smallest legal settings
    add_regs(31'd0, 31'd0, 31'd1, 31'd1);
    add_sample(32'h7FFFFFFF, 32'h80000000);
    add_sample(32'h80000000, 32'h7FFFFFFF);
    add_random(200);
    // zero measurement noise: denominator may vanish
    add_regs(31'd0, 31'd0, 31'd0, 31'd10737418);
    add_random(200);
    add_regs(QA_RESET, QB_RESET, R_RESET, DT_RESET);
    add_random(230);
    add_regs(31'($urandom), 31'($urandom), 31'($urandom_range(32'h7FFFFFFF, 1)),
             31'($urandom_range(1 << 30, 1)));
    add_random(230);
    add_regs(31'($urandom_range(1 << 24)), 31'($urandom_range(1 << 24)),
             31'($urandom_range(1 << 28, 1)), 31'($urandom_range(1 << 26, 1)));
    add_random(240);
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    while (jobs.size() != 0 || angle_q.size() != 0 || s_tvalid) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fails == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // driver
  int gap = 0;
  int settle = 0;
  always @(posedge clk) begin
    logic nv, nwr;
    logic [63:0] nd;
    logic [1:0] ni;
    logic [30:0] nwd;
    nv = 1'b0;
    nd = s_tdata;
    nwr = 1'b0;
    ni = wr_index;
    nwd = wr_data;
    if (!rst) begin
      if (s_tvalid && s_tready) begin
        angle_q.push_back(kalman_step(s_tdata));
        sent++;
      end
      if (s_tvalid && !s_tready) begin
        nv = 1'b1;  // hold until taken
      end else if (gap > 0) begin
        gap--;
      end else if (jobs.size() != 0) begin
        case (jobs[0].kind)
          K_SAMPLE: begin
            if (sent < QUIET_AFTER && $urandom_range(7) == 0) begin
              gap = $urandom_range(17);
            end else begin
              nv = 1'b1;
              nd = jobs[0].data;
              void'(jobs.pop_front());
            end
          end
          K_WRITE: begin
            nwr = 1'b1;
            ni = jobs[0].index;
            nwd = jobs[0].data[30:0];
            case (jobs[0].index)
              REG_QA: qa = nwd;
              REG_QB: qb = nwd;
              REG_R:  rn = nwd;
              REG_DT: dt = nwd;
            endcase
            void'(jobs.pop_front());
          end
          K_DRAIN: begin
            // pause until every result is back and the block is idle
            if (angle_q.size() == 0 && !s_tvalid) begin
              settle++;
              if (settle >= 120) begin
                settle = 0;
                void'(jobs.pop_front());
              end
            end
          end
        endcase
      end
    end
    s_tvalid <= nv;
    s_tdata <= nd;
    wr_en <= nwr;
    wr_index <= ni;
    wr_data <= nwd;
  end

  // monitor
  int stall = 0;
  logic long_hold_done = 1'b0;
  always @(posedge clk) begin
    logic nr;
    logic signed [31:0] want;
    nr = 1'b0;
    if (!rst) begin
      if (m_tvalid && m_tready) begin
        results++;
        if (angle_q.size() == 0) begin
          $error("filtered_angle: no transaction expected, got %0d", $signed(m_tdata));
          fails++;
        end else begin
          want = angle_q.pop_front();
          if (want !== $signed(m_tdata)) begin
            $error("filtered_angle: expected %0d, actual %0d", want, $signed(m_tdata));
            fails++;
          end
        end
      end
      if (!long_hold_done && results == 300) begin
        long_hold_done = 1'b1;
        stall = 600;  // back up the pipe so the input stalls
      end
      if (stall > 0) begin
        stall--;
      end else if (sent < QUIET_AFTER && $urandom_range(7) == 0) begin
        stall = $urandom_range(17);
      end else begin
        nr = 1'b1;
      end
    end
    m_tready <= nr;
  end

endmodule

/* sim.f */
+incdir+hw/rtl
hw/rtl/abkf_pkg.sv
hw/rtl/abkf_div.sv
hw/rtl/abkf_ctrl.sv
hw/rtl/abkf_dpath.sv
hw/rtl/angle_bias_kalman_filter.sv
hw/rtl/abkf_checker.sv
tb/angle_bias_kalman_filter_tb.sv
